>>> rtl/strassen_matrix_multiply_core_defines.svh
// Assertion macros for the Strassen multiply core.
`ifndef STRASSEN_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define STRASSEN_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SMM_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SMM_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SMM_ASSERT(label, clk, rstn, prop, msg)
`define SMM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/smm_pkg.sv
package smm_pkg;
  typedef struct packed {
    logic clr;    // clear accumulator
    logic acc;    // accumulate one term
    logic take;   // move accumulator to output register
  } smm_cmd_t;
endpackage

>>> rtl/strassen_matrix_multiply_core.sv
// channel | valid/ready          | payload
// in      | in_valid/in_ready    | row_i col_i a_elem_i b_elem_i last_i
// out     | out_valid/out_ready  | out_row_o out_col_o c_elem_o out_last_o
// cfg     | cfg_valid/cfg_ready  | cfg_data_i (size_log2)
// Loads take one cycle each while the block is idle. After last, each
// product element is formed term by term (one shared multiplier and
// accumulator, one read of each RAM per term). Input is held off
// until the final element is taken. Reset clears control only; stores
// are undefined until written. A stalled output holds the block.
`include "strassen_matrix_multiply_core_defines.svh"
module strassen_matrix_multiply_core
  import smm_pkg::*;
#(
  parameter int DIM = 4,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            row_i,
  input  logic [1:0]            col_i,
  input  logic signed [31:0]    a_elem_i,
  input  logic signed [31:0]    b_elem_i,
  input  logic                  last_i,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_row_o,
  output logic [1:0]            out_col_o,
  output logic signed [31:0]    c_elem_o,
  output logic                  out_last_o,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_data_i
);
  localparam int DB = $clog2(DIM);
  localparam int AW = (2 * DB > 0) ? 2 * DB : 1;
  localparam int IW = DB + 1;

  logic [1:0] size_q;
  logic busy, start, we;
  logic [IW-1:0] ci, cj, ck;
  smm_cmd_t cmd;
  logic [AW-1:0] waddr, ra, rb;
  logic [ELEM_WIDTH-1:0] a_rd, b_rd, c_full, a_ext, b_ext;

  assign in_ready  = !busy;
  assign cfg_ready = 1'b1;
  assign start = in_valid && in_ready && last_i;
  assign we = in_valid && in_ready && (int'(row_i) < DIM) && (int'(col_i) < DIM);
  assign waddr = AW'(int'(row_i) * DIM + int'(col_i));
  assign ra = AW'(int'(ci) * DIM + int'(ck));
  assign rb = AW'(int'(ck) * DIM + int'(cj));
  assign a_ext = ELEM_WIDTH'({{32{a_elem_i[31]}}, a_elem_i});
  assign b_ext = ELEM_WIDTH'({{32{b_elem_i[31]}}, b_elem_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= 2'd2;
    else if (cfg_valid && cfg_ready) size_q <= cfg_data_i;
  end

  smm_ram #(.Width(ELEM_WIDTH), .Depth(1 << AW)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(a_ext), .raddr_i(ra), .rdata_o(a_rd));
  smm_ram #(.Width(ELEM_WIDTH), .Depth(1 << AW)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(b_ext), .raddr_i(rb), .rdata_o(b_rd));

  smm_ctrl #(.Dim(DIM)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .size_log2_i(size_q), .out_ready_i(out_ready),
    .busy_o(busy), .i_o(ci), .j_o(cj), .k_o(ck), .cmd_o(cmd), .out_valid_o(out_valid),
    .out_row_o, .out_col_o, .out_last_o);

  smm_datapath #(.ElemWidth(ELEM_WIDTH)) u_dp (
    .clk_i, .cmd_i(cmd), .a_i(a_rd), .b_i(b_rd), .c_o(c_full));

  assign c_elem_o = 32'(c_full);

  `SMM_ASSERT(a_no_accept_busy, clk_i, rst_ni, out_valid |-> !in_ready, "input taken during output")
  `SMM_ASSERT(a_start_busy, clk_i, rst_ni, start |=> !in_ready, "start did not engage")
  `SMM_ASSERT(a_last_ends, clk_i, rst_ni, (out_valid && out_ready && out_last_o) |=> !out_valid, "output after final item")
endmodule

>>> rtl/smm_ram.sv
module smm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/smm_datapath.sv
// Multiply-accumulate datapath. The product C = A*B modulo 2^W equals the
// Strassen result exactly, so each element is formed as a dot product.
module smm_datapath
  import smm_pkg::*;
#(
  parameter int ElemWidth = 32
) (
  input  logic                 clk_i,
  input  smm_cmd_t             cmd_i,
  input  logic [ElemWidth-1:0] a_i,
  input  logic [ElemWidth-1:0] b_i,
  output logic [ElemWidth-1:0] c_o
);
  logic [ElemWidth-1:0] prod_q, acc_q, c_q;
  always_ff @(posedge clk_i) begin
    prod_q <= ElemWidth'(a_i * b_i);
    if (cmd_i.clr) acc_q <= '0;
    else if (cmd_i.acc) acc_q <= acc_q + prod_q;
    if (cmd_i.take) c_q <= acc_q;
  end
  assign c_o = c_q;
endmodule

>>> rtl/smm_ctrl.sv
module smm_ctrl
  import smm_pkg::*;
#(
  parameter int Dim = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [1:0]             size_log2_i,
  input  logic                   out_ready_i,
  output logic                   busy_o,
  output logic [$clog2(Dim):0]   i_o,
  output logic [$clog2(Dim):0]   j_o,
  output logic [$clog2(Dim):0]   k_o,
  output smm_cmd_t               cmd_o,
  output logic                   out_valid_o,
  output logic [1:0]             out_row_o,
  output logic [1:0]             out_col_o,
  output logic                   out_last_o
);
  localparam int IW = $clog2(Dim) + 1;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRun  = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0] st_q, st_d;
  logic [IW-1:0] n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [2:0] drain_q, drain_d;
  logic [IW-1:0] n_sel;

  always_comb begin
    n_sel = IW'(1);
    for (int s = 1; s <= 3; s++)
      if (s <= int'(size_log2_i) && (1 << s) <= Dim) n_sel = IW'(1 << s);
  end

  always_comb begin
    st_d = st_q; n_d = n_q; i_d = i_q; j_d = j_q; k_d = k_q; drain_d = drain_q;
    cmd_o = '0;
    case (st_q)
      StIdle: begin
        if (start_i) begin
          n_d = n_sel; i_d = '0; j_d = '0; k_d = '0; st_d = StRun;
          cmd_o.clr = 1'b1;
        end
      end
      StRun: begin
        // read issued at k; product lands after the RAM read register and prod_q
        if (k_q == n_q - IW'(1)) begin
          st_d = StWait; drain_d = 3'd0;
        end else k_d = k_q + IW'(1);
        if (k_q >= IW'(2)) cmd_o.acc = 1'b1;
      end
      StWait: begin
        drain_d = drain_q + 3'd1;
        if (drain_q < 3'd2 && (n_q >= IW'(2) || drain_q == 3'd1)) cmd_o.acc = 1'b1;
        if (n_q == IW'(1) && drain_q == 3'd0) cmd_o.acc = 1'b0;
        if (drain_q == 3'd2) begin
          cmd_o.take = 1'b1; st_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.clr = 1'b1; k_d = '0;
          if (j_q == n_q - IW'(1)) begin
            j_d = '0;
            if (i_q == n_q - IW'(1)) st_d = StIdle;
            else begin i_d = i_q + IW'(1); st_d = StRun; end
          end else begin
            j_d = j_q + IW'(1); st_d = StRun;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; n_q <= IW'(1); i_q <= '0; j_q <= '0; k_q <= '0; drain_q <= '0;
    end else begin
      st_q <= st_d; n_q <= n_d; i_q <= i_d; j_q <= j_d; k_q <= k_d; drain_q <= drain_d;
    end
  end

  assign busy_o      = st_q != StIdle;
  assign i_o         = i_q;
  assign j_o         = j_q;
  assign k_o         = k_q;
  assign out_valid_o = st_q == StOut;
  assign out_row_o   = 2'(i_q);
  assign out_col_o   = 2'(j_q);
  assign out_last_o  = (i_q == n_q - IW'(1)) && (j_q == n_q - IW'(1));
endmodule

>>> tb/strassen_matrix_multiply_core_test.sv
module strassen_matrix_multiply_core_test;

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] a;
    logic [31:0] b;
    logic        last;
  } load_item_t;

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] c;
    logic        last;
  } prod_item_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  row_i = '0;
  logic [1:0]  col_i = '0;
  logic signed [31:0] a_elem_i = '0;
  logic signed [31:0] b_elem_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_row_o;
  logic [1:0]  out_col_o;
  logic signed [31:0] c_elem_o;
  logic        out_last_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data_i = '0;

  strassen_matrix_multiply_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_ready(in_ready),
    .row_i(row_i), .col_i(col_i), .a_elem_i(a_elem_i), .b_elem_i(b_elem_i),
    .last_i(last_i),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_o(out_row_o), .out_col_o(out_col_o), .c_elem_o(c_elem_o),
    .out_last_o(out_last_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  load_item_t  pend_q[$];
  prod_item_t  product_q[$];
  logic [31:0] a_mem[16];
  logic [31:0] b_mem[16];
  logic [1:0]  size_reg = 2'd2;
  logic [15:0] loaded_mask = '0;
  int          pushed_cnt = 0;
  int          accepted_cnt = 0;
  int          fail_cnt = 0;
  int          idle_cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  logic        in_taken = 1'b0;
  logic        quiet = 1'b0;

  function automatic int dim_of(logic [1:0] s);
    int n;
    n = 1 << s;
    if (n > 4) n = 4;
    return n;
  endfunction

  // Strassen is exact in any ring, so a plain product mod 2^32 matches bit for bit.
  task automatic predict_product();
    int n;
    logic [31:0] acc;
    prod_item_t p;
    n = dim_of(size_reg);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) acc += a_mem[4'(i*4+k)] * b_mem[4'(k*4+j)];
        p.row = i[1:0];
        p.col = j[1:0];
        p.c = acc;
        p.last = (i == n-1) && (j == n-1);
        product_q = {product_q, p};
      end
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    prod_item_t p;
    in_taken <= in_valid && in_ready;
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("strassen_matrix_multiply_core_test NOT OK");
        $finish;
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_data_i;
      if (out_valid && out_ready) begin
        if (product_q.size() == 0) begin
          report("unexpected item", c_elem_o, '0);
        end else begin
          p = product_q.pop_front();
          if (out_row_o !== p.row) report("out_row", 32'(out_row_o), 32'(p.row));
          if (out_col_o !== p.col) report("out_col", 32'(out_col_o), 32'(p.col));
          if (c_elem_o !== p.c) report("c_elem", c_elem_o, p.c);
          if (out_last_o !== p.last) report("out_last", 32'(out_last_o), 32'(p.last));
        end
      end
      if (in_valid && in_ready) begin
        accepted_cnt++;
        a_mem[{row_i, col_i}] = a_elem_i;
        b_mem[{row_i, col_i}] = b_elem_i;
        if (last_i) predict_product();
      end
    end
  end

  always @(negedge clk_i) begin
    load_item_t it;
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          it = pend_q.pop_front();
          in_valid <= 1'b1;
          row_i <= it.row;
          col_i <= it.col;
          a_elem_i <= it.a;
          b_elem_i <= it.b;
          last_i <= it.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_load(int r, int c, logic [31:0] a, logic [31:0] b, logic last);
    load_item_t it;
    it.row = r[1:0];
    it.col = c[1:0];
    it.a = a;
    it.b = b;
    it.last = last;
    pend_q = {pend_q, it};
    pushed_cnt++;
    loaded_mask[4'(r*4+c)] = 1'b1;
  endtask

  function automatic bit covered(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!loaded_mask[4'(i*4+j)]) return 0;
    return 1;
  endfunction

  // full load in random order, last on the final pair
  task automatic load_matrix(int n, bit noise);
    int pos[$];
    int k, t;
    for (int i = 0; i < n*n; i++) pos = {pos, (i / n) * 4 + (i % n)};
    for (int i = pos.size() - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = pos[i]; pos[i] = pos[k]; pos[k] = t;
    end
    foreach (pos[i]) begin
      if (noise && $urandom_range(0, 6) == 0)
        add_load($urandom_range(0, 3), $urandom_range(0, 3), rand_elem(), rand_elem(), 1'b0);
      add_load(pos[i] / 4, pos[i] % 4, rand_elem(), rand_elem(), i == pos.size() - 1);
    end
  endtask

  // last on a lone pair, reusing earlier loads; a full load if they do not cover the matrix
  task automatic lone_last(int n);
    if (covered(n))
      add_load($urandom_range(0, n-1), $urandom_range(0, n-1), rand_elem(), rand_elem(), 1'b1);
    else
      load_matrix(n, 1'b0);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (accepted_cnt != pushed_cnt || product_q.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_size(logic [1:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [1:0] v;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_size(2'd2);
    load_matrix(4, 1'b0);
    wait_idle();
    write_size(2'd0);
    add_load(0, 0, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_load(3, 3, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    add_load(0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    wait_idle();
    // dimension above DIM saturates
    write_size(2'd3);
    lone_last(4);
    wait_idle();
    write_size(2'd1);
    load_matrix(2, 1'b0);

    while (pushed_cnt < 330) begin
      if (pushed_cnt > 280) quiet = 1'b1;
      wait_idle();
      v = $urandom_range(0, 3);
      write_size(v);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) lone_last(dim_of(v));
        else load_matrix(dim_of(v), 1'b1);
      end
    end
    quiet = 1'b1;

    do @(negedge clk_i); while (accepted_cnt != pushed_cnt || product_q.size() != 0);
    repeat (40) @(negedge clk_i);
    if (fail_cnt == 0 && product_q.size() == 0)
      $display("strassen_matrix_multiply_core_test OK");
    else
      $display("strassen_matrix_multiply_core_test NOT OK");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/smm_datapath.sv
rtl/smm_ctrl.sv
rtl/strassen_matrix_multiply_core.sv
tb/strassen_matrix_multiply_core_test.sv
